FILE: rtl/core/spmq_pkg.sv
// ============================================================================
// spmq_pkg
// Shared sizes, codes and types of the strict-priority multi-queue.
// ============================================================================
`default_nettype none

package spmq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH  = 16;
    localparam int NUM_LEVELS   = 4;
    localparam int NORMAL_LEVEL = 2;

    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // Field widths
    localparam int QUEUE_W  = 2;
    localparam int PRIO_W   = 3;
    localparam int ID_W     = 32;
    localparam int TYPE_W   = 8;
    localparam int TIME_W   = 64;
    localparam int STATUS_W = 2;

    // Stream word widths, padded to whole bytes
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 144;
    localparam int OUT_USED_W = QUEUE_W + PRIO_W + 2 * ID_W + TYPE_W + TIME_W;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

    // Operation codes
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_PUSHED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POPPED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    // One stored event record
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   sensor_id;
        logic [ID_W-1:0]   event_id;
        logic [TYPE_W-1:0] sensor_code;
        logic [TIME_W-1:0] timestamp;
    } record_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                push;
        logic                pop;
        logic                load_result;
        logic                load_record;
        logic [STATUS_W-1:0] status;
        logic [QUEUE_W-1:0]  queue;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [QUEUE_W-1:0] push_queue;
        logic               push_full;
        logic               pop_any;
        logic [QUEUE_W-1:0] pop_queue;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/spmq_dp.sv
// ============================================================================
// spmq_dp
// Datapath: per-queue pointers and fill counts, the record memory and the
// result register.
// ============================================================================
`default_nettype none

module spmq_dp (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic [spmq_pkg::IN_DATA_W-1:0]      s_tdata,
    input  wire spmq_pkg::cmd_t                      cmd,
    output spmq_pkg::sts_t                           sts,
    output logic [spmq_pkg::STATUS_W-1:0]            m_tuser,
    output logic [spmq_pkg::OUT_DATA_W-1:0]          m_tdata
);

    logic [spmq_pkg::PTR_W-1:0]   wptr_reg  [spmq_pkg::NUM_LEVELS];
    logic [spmq_pkg::PTR_W-1:0]   rptr_reg  [spmq_pkg::NUM_LEVELS];
    logic [spmq_pkg::CNT_W-1:0]   count_reg [spmq_pkg::NUM_LEVELS];

    spmq_pkg::record_t            mem [spmq_pkg::MEM_DEPTH];
    spmq_pkg::record_t            rd_data_reg;
    spmq_pkg::record_t            rec_in;
    spmq_pkg::record_t            out_rec_reg;

    logic [spmq_pkg::STATUS_W-1:0] status_reg;
    logic [spmq_pkg::QUEUE_W-1:0]  served_reg;
    logic [spmq_pkg::PRIO_W-1:0]   in_prio;
    logic [spmq_pkg::ADDR_W-1:0]   wr_addr;
    logic [spmq_pkg::ADDR_W-1:0]   rd_addr;

    // Unpack the incoming word
    assign in_prio            = s_tdata[2:0];
    assign rec_in.prio        = in_prio;
    assign rec_in.sensor_id   = s_tdata[34:3];
    assign rec_in.event_id    = s_tdata[66:35];
    assign rec_in.sensor_code = s_tdata[74:67];
    assign rec_in.timestamp   = s_tdata[138:75];

    // Build the status for the controller
    always_comb begin
        sts = '0;
        // Select the push queue; out-of-range priorities land in the normal queue
        if (in_prio < spmq_pkg::PRIO_W'(spmq_pkg::NUM_LEVELS)) begin
            sts.push_queue = in_prio[spmq_pkg::QUEUE_W-1:0];
        end else begin
            sts.push_queue = spmq_pkg::QUEUE_W'(spmq_pkg::NORMAL_LEVEL);
        end
        sts.push_full =
            (count_reg[sts.push_queue] == spmq_pkg::CNT_W'(spmq_pkg::QUEUE_DEPTH));
        // Find the highest-priority non-empty queue (lowest index wins)
        for (int i = spmq_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
            if (count_reg[i] != '0) begin
                sts.pop_any   = 1'b1;
                sts.pop_queue = spmq_pkg::QUEUE_W'(i);
            end
        end
    end

    // Flat memory addresses: queue base plus ring pointer
    assign wr_addr = spmq_pkg::ADDR_W'(sts.push_queue)
                   * spmq_pkg::ADDR_W'(spmq_pkg::QUEUE_DEPTH)
                   + spmq_pkg::ADDR_W'(wptr_reg[sts.push_queue]);
    assign rd_addr = spmq_pkg::ADDR_W'(sts.pop_queue)
                   * spmq_pkg::ADDR_W'(spmq_pkg::QUEUE_DEPTH)
                   + spmq_pkg::ADDR_W'(rptr_reg[sts.pop_queue]);

    // Advance pointers and fill counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < spmq_pkg::NUM_LEVELS; i++) begin
                wptr_reg[i]  <= '0;
                rptr_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            if (cmd.push) begin
                if (wptr_reg[sts.push_queue] == spmq_pkg::PTR_W'(spmq_pkg::QUEUE_DEPTH - 1)) begin
                    wptr_reg[sts.push_queue] <= '0;
                end else begin
                    wptr_reg[sts.push_queue] <= wptr_reg[sts.push_queue] + 1'b1;
                end
                count_reg[sts.push_queue] <= count_reg[sts.push_queue] + 1'b1;
            end
            if (cmd.pop) begin
                if (rptr_reg[sts.pop_queue] == spmq_pkg::PTR_W'(spmq_pkg::QUEUE_DEPTH - 1)) begin
                    rptr_reg[sts.pop_queue] <= '0;
                end else begin
                    rptr_reg[sts.pop_queue] <= rptr_reg[sts.pop_queue] + 1'b1;
                end
                count_reg[sts.pop_queue] <= count_reg[sts.pop_queue] - 1'b1;
            end
        end
    end

    // Record memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[wr_addr] <= rec_in;
        end
        if (cmd.pop) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Result register: status first, record fields in the following cycle on a pop
    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            status_reg  <= cmd.status;
            served_reg  <= cmd.queue;
            out_rec_reg <= '0;
        end else if (cmd.load_record) begin
            out_rec_reg <= rd_data_reg;
        end
    end

    assign m_tuser = status_reg;
    assign m_tdata = {{spmq_pkg::OUT_PAD_W{1'b0}},
                      out_rec_reg.timestamp,
                      out_rec_reg.sensor_code,
                      out_rec_reg.event_id,
                      out_rec_reg.sensor_id,
                      out_rec_reg.prio,
                      served_reg};

endmodule

`default_nettype wire

FILE: rtl/core/spmq_ctrl.sv
// ============================================================================
// spmq_ctrl
// Controller: input and output handshakes, operation decode and the
// memory read wait state.
// ============================================================================
`default_nettype none

module spmq_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    input  wire logic           s_tuser,     // mode
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    input  wire spmq_pkg::sts_t sts,
    output spmq_pkg::cmd_t      cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic state_reg;
    logic state_next;
    logic m_tvalid_reg;
    logic m_tvalid_next;
    logic in_fire;

    // Take a word when idle and the result slot is free or draining now
    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    // Decode the operation and sequence the pop read
    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cmd.load_result = 1'b1;
                    if (s_tuser == spmq_pkg::MODE_PUSH) begin
                        cmd.queue     = sts.push_queue;
                        cmd.push      = !sts.push_full;
                        cmd.status    = sts.push_full ? spmq_pkg::ST_FULL
                                                      : spmq_pkg::ST_PUSHED;
                        m_tvalid_next = 1'b1;
                    end else if (sts.pop_any) begin
                        cmd.queue  = sts.pop_queue;
                        cmd.pop    = 1'b1;
                        cmd.status = spmq_pkg::ST_POPPED;
                        state_next = S_READ;
                    end else begin
                        cmd.status    = spmq_pkg::ST_EMPTY;
                        m_tvalid_next = 1'b1;
                    end
                end
            end
            S_READ: begin
                cmd.load_record = 1'b1;
                m_tvalid_next   = 1'b1;
                state_next      = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/strict_priority_multi_queue.sv
// ============================================================================
// strict_priority_multi_queue
// Four ring FIFOs of event records served in strict priority order.
//
//   channel  | direction | tuser   | tdata (low bit up)
//   ---------+-----------+---------+----------------------------------------
//   s_       | in        | mode    | priority_req, sensor_id, event_id,
//            |           |         | sensor_code, timestamp
//   m_       | out       | status  | served_queue, out_priority,
//            |           |         | out_sensor_id, out_event_id,
//            |           |         | out_sensor_code, out_timestamp
//
// A push, or a pop that finds every queue empty, is answered from the idle state.
// A pop that returns a record passes through a read state: the record memory read
// port is registered.
// Reset clears pointers and fill counts at once; the record memory is not
// cleared and needs no pass.
// A stalled result is held; the next word is accepted in the cycle the
// held result is taken.
// ============================================================================
`default_nettype none

module strict_priority_multi_queue (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [0] mode
    input  wire logic                                s_tuser,
    // [2:0] priority_req, [34:3] sensor_id, [66:35] event_id,
    // [74:67] sensor_code, [138:75] timestamp, [143:139] zero
    input  wire logic [spmq_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [1:0] status
    output logic [spmq_pkg::STATUS_W-1:0]            m_tuser,
    // [1:0] served_queue, [4:2] out_priority, [36:5] out_sensor_id,
    // [68:37] out_event_id, [76:69] out_sensor_code, [140:77] out_timestamp,
    // [143:141] zero
    output logic [spmq_pkg::OUT_DATA_W-1:0]          m_tdata
);

    spmq_pkg::cmd_t cmd;
    spmq_pkg::sts_t sts;

    spmq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spmq_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    // Never write into a full queue
    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> !sts.push_full)
        else $error("push issued to a full queue");

    // A pop is followed by the record load, with input held off meanwhile
    a_pop_then_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |=> (cmd.load_record && !s_tready))
        else $error("pop not followed by record load");

    // The record lands only in an empty result slot
    a_load_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_record |-> !m_tvalid)
        else $error("record load over a pending result");

    // A pop never returns an empty status
    a_pop_status: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |=> (m_tuser == spmq_pkg::ST_POPPED))
        else $error("pop result carries wrong status");

endmodule

`default_nettype wire

FILE: bench/strict_priority_multi_queue_tb.sv
// ----------------------------------------------------------------------------
// strict_priority_multi_queue_tb
// Self-checking bench for the four-level strict-priority event queue. A
// clocked driver sends push and pop words from a backlog in bursts. A clocked
// monitor stalls the result channel on its own pattern. Every accepted result
// is compared field by field with an in-bench model of the four ring FIFOs.
// The stimulus covers fill runs, drain runs and mixed traffic, so that
// overflow, pointer wrap, remapped priorities and empty pops all occur.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module strict_priority_multi_queue_tb;

    localparam int RANDOM_WORDS = 800;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int IN_USED_W    = spmq_pkg::PRIO_W + 2 * spmq_pkg::ID_W
                                + spmq_pkg::TYPE_W + spmq_pkg::TIME_W;
    localparam int IN_PAD_W     = spmq_pkg::IN_DATA_W - IN_USED_W;

    // Input word layout, lowest field last
    typedef struct packed {
        logic [IN_PAD_W-1:0]           pad;
        logic [spmq_pkg::TIME_W-1:0]   timestamp;
        logic [spmq_pkg::TYPE_W-1:0]   sensor_code;
        logic [spmq_pkg::ID_W-1:0]     event_id;
        logic [spmq_pkg::ID_W-1:0]     sensor_id;
        logic [spmq_pkg::PRIO_W-1:0]   prio;
    } in_word_t;

    // Result word layout, lowest field last
    typedef struct packed {
        logic [spmq_pkg::OUT_PAD_W-1:0] pad;
        logic [spmq_pkg::TIME_W-1:0]    timestamp;
        logic [spmq_pkg::TYPE_W-1:0]    sensor_code;
        logic [spmq_pkg::ID_W-1:0]      event_id;
        logic [spmq_pkg::ID_W-1:0]      sensor_id;
        logic [spmq_pkg::PRIO_W-1:0]    prio;
        logic [spmq_pkg::QUEUE_W-1:0]   queue;
    } out_word_t;

    typedef struct {
        logic                        wait_idle;
        logic                        mode;
        logic [spmq_pkg::PRIO_W-1:0] prio;
        logic [spmq_pkg::ID_W-1:0]   sensor_id;
        logic [spmq_pkg::ID_W-1:0]   event_id;
        logic [spmq_pkg::TYPE_W-1:0] sensor_code;
        logic [spmq_pkg::TIME_W-1:0] timestamp;
    } dispatch_req_t;

    typedef struct {
        logic [spmq_pkg::STATUS_W-1:0] status;
        logic [spmq_pkg::QUEUE_W-1:0]  queue;
        logic [spmq_pkg::PRIO_W-1:0]   prio;
        logic [spmq_pkg::ID_W-1:0]     sensor_id;
        logic [spmq_pkg::ID_W-1:0]     event_id;
        logic [spmq_pkg::TYPE_W-1:0]   sensor_code;
        logic [spmq_pkg::TIME_W-1:0]   timestamp;
    } dispatch_res_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic                            s_tuser  = spmq_pkg::MODE_PUSH;
    logic [spmq_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [spmq_pkg::STATUS_W-1:0]   m_tuser;
    logic [spmq_pkg::OUT_DATA_W-1:0] m_tdata;

    dispatch_req_t     request_backlog[$];
    dispatch_res_t     awaited_outcomes[$];
    spmq_pkg::record_t level_fifo[spmq_pkg::NUM_LEVELS][$];
    int                mismatches = 0;

    strict_priority_multi_queue u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Run the scheduler model for one accepted word and return its result
    function automatic dispatch_res_t serve_request(dispatch_req_t req);
        dispatch_res_t     res;
        spmq_pkg::record_t rec;
        int                lvl;
        logic              found;
        res = '{default: '0};
        found = 1'b0;
        if (req.mode == spmq_pkg::MODE_PUSH) begin
            lvl = (req.prio < spmq_pkg::NUM_LEVELS) ? int'(req.prio)
                                                    : spmq_pkg::NORMAL_LEVEL;
            res.queue = spmq_pkg::QUEUE_W'(lvl);
            if (level_fifo[lvl].size() >= spmq_pkg::QUEUE_DEPTH) begin
                res.status = spmq_pkg::ST_FULL;
            end else begin
                rec.prio        = req.prio;
                rec.sensor_id   = req.sensor_id;
                rec.event_id    = req.event_id;
                rec.sensor_code = req.sensor_code;
                rec.timestamp   = req.timestamp;
                level_fifo[lvl].push_back(rec);
                res.status = spmq_pkg::ST_PUSHED;
            end
        end else begin
            res.status = spmq_pkg::ST_EMPTY;
            for (int l = 0; l < spmq_pkg::NUM_LEVELS; l++) begin
                if (!found && level_fifo[l].size() > 0) begin
                    found = 1'b1;
                    rec = level_fifo[l].pop_front();
                    res.status      = spmq_pkg::ST_POPPED;
                    res.queue       = spmq_pkg::QUEUE_W'(l);
                    res.prio        = rec.prio;
                    res.sensor_id   = rec.sensor_id;
                    res.event_id    = rec.event_id;
                    res.sensor_code = rec.sensor_code;
                    res.timestamp   = rec.timestamp;
                end
            end
        end
        return res;
    endfunction

    // Build a word with random payload; pops carry junk the block must ignore
    function automatic dispatch_req_t random_req(logic mode,
                                                 logic [spmq_pkg::PRIO_W-1:0] prio);
        dispatch_req_t req;
        req.wait_idle = 1'b0;
        req.mode      = mode;
        req.prio      = prio;
        case ($urandom_range(0, 7))
            0: begin
                req.sensor_id   = '0;
                req.event_id    = '0;
                req.sensor_code = '0;
                req.timestamp   = '0;
            end
            1: begin
                req.sensor_id   = '1;
                req.event_id    = '1;
                req.sensor_code = '1;
                req.timestamp   = '1;
            end
            default: begin
                req.sensor_id   = $urandom;
                req.event_id    = $urandom;
                req.sensor_code = spmq_pkg::TYPE_W'($urandom);
                req.timestamp   = {$urandom, $urandom};
            end
        endcase
        return req;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] seen);
        if (want !== seen) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, seen);
            mismatches++;
        end
    endtask

    // Driver: offer backlog words in bursts, predict each word as it is taken
    int            burst_left = 0;
    int            gap_left   = 0;
    dispatch_req_t offered;

    always @(posedge aclk) begin
        dispatch_req_t nxt;
        in_word_t      w;
        logic          load;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                awaited_outcomes.push_back(serve_request(offered));
            end
            if (!s_tvalid || s_tready) begin
                load = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_backlog.size() > 0 &&
                             !(request_backlog[0].wait_idle && awaited_outcomes.size() != 0)) begin
                    load = 1'b1;
                    nxt = request_backlog.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end
                s_tvalid <= load;
                if (load) begin
                    offered       = nxt;
                    w.pad         = '0;
                    w.timestamp   = nxt.timestamp;
                    w.sensor_code = nxt.sensor_code;
                    w.event_id    = nxt.event_id;
                    w.sensor_id   = nxt.sensor_id;
                    w.prio        = nxt.prio;
                    s_tuser <= nxt.mode;
                    s_tdata <= w;
                end
            end
        end
    end

    // Monitor: check each result word, stall the result channel in segments
    int rx_count  = 0;
    int hold_left = 0;
    int seg_left  = 0;
    int stall_pct = 0;

    always @(posedge aclk) begin
        dispatch_res_t want;
        out_word_t     got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (awaited_outcomes.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual status %0d data %h",
                             $time, m_tuser, m_tdata);
                    mismatches++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    check_field("status", 64'(want.status), 64'(m_tuser));
                    check_field("served_queue", 64'(want.queue), 64'(got.queue));
                    check_field("out_priority", 64'(want.prio), 64'(got.prio));
                    check_field("out_sensor_id", 64'(want.sensor_id), 64'(got.sensor_id));
                    check_field("out_event_id", 64'(want.event_id), 64'(got.event_id));
                    check_field("out_sensor_code", 64'(want.sensor_code),
                                64'(got.sensor_code));
                    check_field("out_timestamp", want.timestamp, got.timestamp);
                    check_field("tdata padding", 64'd0, 64'(got.pad));
                end
                rx_count++;
                // Hold off long enough for the block to back up onto its input
                if (rx_count == 150 || rx_count == 600) begin
                    hold_left = LONG_HOLD;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(20, 120);
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 20;
                        2:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                seg_left--;
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Stimulus and end of run
    initial begin
        dispatch_req_t               req;
        int                          placed;
        int                          len;
        int                          kind;
        logic [spmq_pkg::PRIO_W-1:0] lvl;
        placed = 0;

        // Pop with every queue empty
        request_backlog.push_back(random_req(spmq_pkg::MODE_POP, 3'd0));
        // One push per priority, extremes of the payload at both ends
        for (int p = 0; p < 8; p++) begin
            req = random_req(spmq_pkg::MODE_PUSH, spmq_pkg::PRIO_W'(p));
            if (p == 0) begin
                req.sensor_id = '0; req.event_id = '0; req.sensor_code = '0; req.timestamp = '0;
            end else if (p == 1 || p == 7) begin
                req.sensor_id = '1; req.event_id = '1; req.sensor_code = '1; req.timestamp = '1;
            end
            request_backlog.push_back(req);
        end
        // Drain in priority order, remapped priorities coming out of the normal queue
        for (int k = 0; k < 9; k++) begin
            request_backlog.push_back(random_req(spmq_pkg::MODE_POP,
                                                 spmq_pkg::PRIO_W'($urandom_range(0, 7))));
        end

        // Random sequences: mixed traffic, fill runs that overflow, drain runs
        while (placed < RANDOM_WORDS) begin
            kind = $urandom_range(0, 9);
            lvl  = spmq_pkg::PRIO_W'($urandom_range(0, 7));
            if (kind <= 3) begin
                len = $urandom_range(8, 40);
            end else if (kind <= 6) begin
                len = $urandom_range(12, 22);
            end else begin
                len = $urandom_range(8, 60);
            end
            for (int k = 0; k < len; k++) begin
                if (kind <= 3) begin
                    req = random_req(($urandom_range(0, 99) < 55) ? spmq_pkg::MODE_PUSH
                                                                  : spmq_pkg::MODE_POP,
                                     spmq_pkg::PRIO_W'($urandom_range(0, 7)));
                end else if (kind <= 6) begin
                    req = random_req(($urandom_range(0, 9) == 0) ? spmq_pkg::MODE_POP
                                                                 : spmq_pkg::MODE_PUSH,
                                     lvl);
                end else begin
                    req = random_req(($urandom_range(0, 9) == 0) ? spmq_pkg::MODE_PUSH
                                                                 : spmq_pkg::MODE_POP,
                                     spmq_pkg::PRIO_W'($urandom_range(0, 7)));
                end
                // Pause the sender until every result is back
                if (k == 0 && (placed == 0 || $urandom_range(0, 5) == 0)) begin
                    req.wait_idle = 1'b1;
                end
                request_backlog.push_back(req);
            end
            placed += len;
        end

        @(posedge aclk);
        while (!aresetn || request_backlog.size() != 0 || s_tvalid) @(posedge aclk);
        while (awaited_outcomes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
